// File: rtl/radius_neighbor_graph_builder_unit_defines.svh
// Assertion macros for the neighbor graph block.
`ifndef RADIUS_NEIGHBOR_GRAPH_BUILDER_UNIT_DEFINES_SVH
`define RADIUS_NEIGHBOR_GRAPH_BUILDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RNB_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("rnb assertion failed");
`define RNB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rnb assertion failed");
`define RNB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rnb assertion failed");
`else
`define RNB_ASSERT_ALWAYS(lbl, expr)
`define RNB_ASSERT_IMP(lbl, ante, cons)
`define RNB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/rnb_pkg.sv
package rnb_pkg;

    localparam int COORD_W   = 16;
    localparam int IDX_W     = 6;
    localparam int LDIST_W   = 17;
    localparam int SQ_W      = 34;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic REG_LINK_DISTANCE = 1'b0;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [IDX_W-1:0]          first_point;
        logic [IDX_W-1:0]          second_point;
    } t_req;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] point_index;
        logic [IDX_W-1:0] links_made;
        logic             list_overflow;
        logic             is_adjacent;
    } t_rsp;

endpackage

// File: rtl/rnb_ram.sv
module rnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/radius_neighbor_graph_builder_unit.sv
// Add: the new point is compared with each stored point in turn (read, square x, y and z, compare,
//   link on a match); one shared 17x17 squaring multiplier; input ready again once the result loads.
// Query: compares the first point's neighbor list entry by entry, stopping when the entry is found.
// Clear, refused add, query of an unknown point and unused codes go straight to the result.
// Synchronous active-low reset clears the sequencer, point count, link distance and
// output valid; RAM contents are left as they are, no clearing pass.
`include "radius_neighbor_graph_builder_unit_defines.svh"

module radius_neighbor_graph_builder_unit #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rnb_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rnb_pkg::t_rsp                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rnb_pkg::APB_AW-1:0]    paddr,
    input  logic [rnb_pkg::APB_DW-1:0]    pwdata,
    output logic [rnb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int LW = $clog2(MAX_DEGREE + 1);
    localparam int NW = $clog2(MAX_POINTS * MAX_DEGREE);
    localparam int QW = (CW > rnb_pkg::IDX_W) ? CW : rnb_pkg::IDX_W;
    localparam int XW = 3 * rnb_pkg::COORD_W;
    localparam int SW = rnb_pkg::SQ_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_THR  = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_SQX  = 4'd3;
    localparam logic [3:0] ST_SQY  = 4'd4;
    localparam logic [3:0] ST_SQZ  = 4'd5;
    localparam logic [3:0] ST_CMP  = 4'd6;
    localparam logic [3:0] ST_LNK  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_QRD  = 4'd9;
    localparam logic [3:0] ST_QNRD = 4'd10;
    localparam logic [3:0] ST_QCMP = 4'd11;
    localparam logic [3:0] ST_DONE = 4'd12;

    function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

    function automatic logic [NW-1:0] nbr_addr(input logic [PW-1:0] owner,
                                               input logic [LW-1:0] slot);
        return NW'(owner) * NW'(MAX_DEGREE) + NW'(slot);
    endfunction

    logic [3:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [rnb_pkg::LDIST_W-1:0] r_link_dist;
    logic [SW-1:0]             r_thr, n_thr;
    logic signed [15:0]        r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [PW-1:0]             r_n, n_n, r_i, n_i, r_qa, n_qa;
    logic [rnb_pkg::IDX_W-1:0] r_qb, n_qb;
    logic [LW-1:0]             r_len_n, n_len_n, r_k, n_k;
    logic [CW-1:0]             r_links, n_links;
    logic                      r_ovf, n_ovf;
    logic [SW-1:0]             r_prod, n_prod, r_acc, n_acc;
    rnb_pkg::t_rsp             r_res, n_res;
    logic                      r_out_valid, n_out_valid;
    rnb_pkg::t_rsp             r_out_data, n_out_data;

    logic                      w_accept;
    logic [16:0]               w_op;
    logic [SW-1:0]             w_sq, w_sum;
    logic                      w_match;
    logic [PW-1:0]             w_i_next;
    logic                      w_last;

    logic                      crd_we, crd_re;
    logic [XW-1:0]             crd_rdata;
    logic                      len_we, len_re;
    logic [PW-1:0]             len_waddr, len_raddr;
    logic [LW-1:0]             len_wdata, len_rd;
    logic                      nbr_we, nbr_re;
    logic [NW-1:0]             nbr_waddr, nbr_raddr;
    logic [PW-1:0]             nbr_wdata, nbr_rdata;
    logic                      w_room_i, w_room_n;
    logic                      cfg_wr;

    rnb_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (crd_we),
        .i_waddr (r_n),
        .i_wdata ({r_px, r_py, r_pz}),
        .i_re    (crd_re),
        .i_raddr (r_i),
        .o_rdata (crd_rdata)
    );

    rnb_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (len_raddr),
        .o_rdata (len_rd)
    );

    rnb_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS * MAX_DEGREE)) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_re    (nbr_re),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rnb_pkg::REG_LINK_DISTANCE);
    assign prdata = (paddr[2] == rnb_pkg::REG_LINK_DISTANCE) ?
                    rnb_pkg::APB_DW'(r_link_dist) : '0;

    always_comb begin
        case (r_state)
            ST_THR:  w_op = r_link_dist;
            ST_SQX:  w_op = abs_diff(crd_rdata[47:32], r_px);
            ST_SQY:  w_op = abs_diff(crd_rdata[31:16], r_py);
            ST_SQZ:  w_op = abs_diff(crd_rdata[15:0], r_pz);
            default: w_op = '0;
        endcase
    end

    assign w_sq     = SW'(w_op) * SW'(w_op);
    assign w_sum    = r_acc + r_prod;
    assign w_match  = (w_sum <= r_thr);
    assign w_i_next = r_i + PW'(1);
    assign w_last   = (w_i_next == r_n);
    assign w_room_i = (len_rd < LW'(MAX_DEGREE));
    assign w_room_n = (r_len_n < LW'(MAX_DEGREE));

    assign crd_we    = (r_state == ST_THR);
    assign crd_re    = (r_state == ST_RD);
    assign len_re    = (r_state == ST_RD) || (r_state == ST_QRD);
    assign len_raddr = (r_state == ST_QRD) ? r_qa : r_i;
    assign len_we    = ((r_state == ST_CMP) && w_match && w_room_i) || (r_state == ST_FIN);
    assign len_waddr = (r_state == ST_FIN) ? r_n : r_i;
    assign len_wdata = (r_state == ST_FIN) ? r_len_n : len_rd + LW'(1);
    assign nbr_we    = ((r_state == ST_CMP) && w_match && w_room_i) ||
                       ((r_state == ST_LNK) && w_room_n);
    assign nbr_waddr = (r_state == ST_CMP) ? nbr_addr(r_i, len_rd) : nbr_addr(r_n, r_len_n);
    assign nbr_wdata = (r_state == ST_CMP) ? r_n : r_i;
    assign nbr_re    = (r_state == ST_QNRD) && (r_k < len_rd);
    assign nbr_raddr = nbr_addr(r_qa, r_k);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_thr       = r_thr;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_n         = r_n;
        n_i         = r_i;
        n_qa        = r_qa;
        n_qb        = r_qb;
        n_len_n     = r_len_n;
        n_k         = r_k;
        n_links     = r_links;
        n_ovf       = r_ovf;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res   = '0;
                    n_state = ST_DONE;
                    case (i_in_data.req_type)
                        rnb_pkg::REQ_CLEAR: begin
                            n_count = '0;
                        end
                        rnb_pkg::REQ_ADD: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_px    = i_in_data.pos_x;
                                n_py    = i_in_data.pos_y;
                                n_pz    = i_in_data.pos_z;
                                n_n     = PW'(r_count);
                                n_i     = '0;
                                n_links = '0;
                                n_ovf   = 1'b0;
                                n_len_n = '0;
                                n_state = ST_THR;
                            end
                        end
                        rnb_pkg::REQ_QUERY: begin
                            if (QW'(i_in_data.first_point) < QW'(r_count)) begin
                                n_qa    = PW'(i_in_data.first_point);
                                n_qb    = i_in_data.second_point;
                                n_k     = '0;
                                n_state = ST_QRD;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_THR: begin
                n_thr   = w_sq;
                n_state = (r_n == '0) ? ST_FIN : ST_RD;
            end
            ST_RD: begin
                n_state = ST_SQX;
            end
            ST_SQX: begin
                n_prod  = w_sq;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_prod  = w_sq;
                n_acc   = r_prod;
                n_state = ST_SQZ;
            end
            ST_SQZ: begin
                n_prod  = w_sq;
                n_acc   = r_acc + r_prod;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (w_match) begin
                    n_links = r_links + CW'(1);
                    if (!w_room_i) begin
                        n_ovf = 1'b1;
                    end
                    n_state = ST_LNK;
                end else begin
                    n_i     = w_i_next;
                    n_state = w_last ? ST_FIN : ST_RD;
                end
            end
            ST_LNK: begin
                if (w_room_n) begin
                    n_len_n = r_len_n + LW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_i     = w_i_next;
                n_state = w_last ? ST_FIN : ST_RD;
            end
            ST_FIN: begin
                n_count             = CW'(r_n) + CW'(1);
                n_res.point_index   = rnb_pkg::IDX_W'(r_n);
                n_res.links_made    = rnb_pkg::IDX_W'(r_links);
                n_res.list_overflow = r_ovf;
                n_state             = ST_DONE;
            end
            ST_QRD: begin
                n_state = ST_QNRD;
            end
            ST_QNRD: begin
                n_state = (r_k < len_rd) ? ST_QCMP : ST_DONE;
            end
            ST_QCMP: begin
                if (QW'(nbr_rdata) == QW'(r_qb)) begin
                    n_res.is_adjacent = 1'b1;
                    n_state           = ST_DONE;
                end else begin
                    n_k     = r_k + LW'(1);
                    n_state = ST_QNRD;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_len_n     <= '0;
            r_out_valid <= 1'b0;
            r_link_dist <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len_n     <= n_len_n;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_link_dist <= pwdata[rnb_pkg::LDIST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr      <= n_thr;
        r_px       <= n_px;
        r_py       <= n_py;
        r_pz       <= n_pz;
        r_n        <= n_n;
        r_i        <= n_i;
        r_qa       <= n_qa;
        r_qb       <= n_qb;
        r_k        <= n_k;
        r_links    <= n_links;
        r_ovf      <= n_ovf;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    `RNB_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(MAX_POINTS))
    `RNB_ASSERT_ALWAYS(a_degree_bound, r_len_n <= LW'(MAX_DEGREE))
    `RNB_ASSERT_IMP(a_loop_index, (r_state == ST_RD) || (r_state == ST_CMP) || (r_state == ST_LNK), r_i < r_n)
    `RNB_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready)

endmodule

// File: bench/neighbor_graph_checker.sv
module neighbor_graph_checker #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  rnb_pkg::t_req                 i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  rnb_pkg::t_rsp                 i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [rnb_pkg::APB_AW-1:0]    i_paddr,
    input  logic [rnb_pkg::APB_DW-1:0]    i_pwdata,
    output int                            o_pending,
    output int                            o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rnb_pkg::APB_AW-1:0] LINK_DIST_ADDR =
        rnb_pkg::APB_AW'(4 * int'(rnb_pkg::REG_LINK_DISTANCE));
    localparam int PRINT_LIMIT = 100;

    logic signed [rnb_pkg::COORD_W-1:0] pt_x [MAX_POINTS];
    logic signed [rnb_pkg::COORD_W-1:0] pt_y [MAX_POINTS];
    logic signed [rnb_pkg::COORD_W-1:0] pt_z [MAX_POINTS];
    logic [rnb_pkg::IDX_W-1:0]          nbr_list [MAX_POINTS][MAX_DEGREE];
    int                                 nbr_len [MAX_POINTS];
    int                                 stored_points = 0;
    logic [rnb_pkg::LDIST_W-1:0]        link_dist = '0;
    rnb_pkg::t_rsp                      expected_rsp [$];
    int                                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic note_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: %s got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit add_neighbor(int owner, int idx);
        if (nbr_len[owner] >= MAX_DEGREE)
            return 1'b0;
        nbr_list[owner][nbr_len[owner]] = rnb_pkg::IDX_W'(idx);
        nbr_len[owner]++;
        return 1'b1;
    endfunction

    function automatic rnb_pkg::t_rsp predict_response(rnb_pkg::t_req r);
        rnb_pkg::t_rsp rsp;
        int     n;
        int     links;
        longint dx;
        longint dy;
        longint dz;
        longint thr;
        rsp = '0;
        links = 0;
        case (r.req_type)
            rnb_pkg::REQ_CLEAR: begin
                stored_points = 0;
            end
            rnb_pkg::REQ_ADD: begin
                if (stored_points >= MAX_POINTS) begin
                    rsp.status = 1'b1;
                end else begin
                    n = stored_points;
                    thr = longint'(link_dist) * longint'(link_dist);
                    pt_x[n] = r.pos_x;
                    pt_y[n] = r.pos_y;
                    pt_z[n] = r.pos_z;
                    nbr_len[n] = 0;
                    for (int i = 0; i < n; i++) begin
                        dx = longint'(pt_x[i]) - longint'(pt_x[n]);
                        dy = longint'(pt_y[i]) - longint'(pt_y[n]);
                        dz = longint'(pt_z[i]) - longint'(pt_z[n]);
                        if (dx * dx + dy * dy + dz * dz <= thr) begin
                            links++;
                            if (!add_neighbor(i, n))
                                rsp.list_overflow = 1'b1;
                            if (!add_neighbor(n, i))
                                rsp.list_overflow = 1'b1;
                        end
                    end
                    stored_points = n + 1;
                    rsp.point_index = rnb_pkg::IDX_W'(n);
                    rsp.links_made = rnb_pkg::IDX_W'(links);
                end
            end
            rnb_pkg::REQ_QUERY: begin
                if (int'(r.first_point) < stored_points && int'(r.first_point) < MAX_POINTS) begin
                    for (int k = 0; k < nbr_len[r.first_point]; k++) begin
                        if (nbr_list[r.first_point][k] == r.second_point)
                            rsp.is_adjacent = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        rnb_pkg::t_rsp want;
        if (!i_rst_n) begin
            stored_points = 0;
            link_dist = '0;
            expected_rsp.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LINK_DIST_ADDR)
                link_dist = i_pwdata[rnb_pkg::LDIST_W-1:0];
            if (i_in_valid && i_in_ready)
                expected_rsp.push_back(predict_response(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_rsp.size() == 0) begin
                    note_mismatch("result with nothing outstanding", int'(i_out_data), 0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (i_out_data.status !== want.status)
                        note_mismatch("status", i_out_data.status, want.status);
                    if (i_out_data.point_index !== want.point_index)
                        note_mismatch("point_index", i_out_data.point_index, want.point_index);
                    if (i_out_data.links_made !== want.links_made)
                        note_mismatch("links_made", i_out_data.links_made, want.links_made);
                    if (i_out_data.list_overflow !== want.list_overflow)
                        note_mismatch("list_overflow", i_out_data.list_overflow,
                                      want.list_overflow);
                    if (i_out_data.is_adjacent !== want.is_adjacent)
                        note_mismatch("is_adjacent", i_out_data.is_adjacent, want.is_adjacent);
                end
            end
            o_pending <= expected_rsp.size();
        end
    end

endmodule

// File: bench/tb_radius_neighbor_graph_builder_unit.sv
module tb_radius_neighbor_graph_builder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_POINTS = 64;
    localparam int NUM_DEGREE = 8;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CW = rnb_pkg::COORD_W;
    localparam int IW = rnb_pkg::IDX_W;
    localparam int DW = rnb_pkg::LDIST_W;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [DW-1:0] LINK_DIST_MAX = '1;
    localparam logic [CW-1:0] COORD_MIN = 16'h8000;
    localparam logic [CW-1:0] COORD_MAX = 16'h7FFF;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    rnb_pkg::t_req                 i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    rnb_pkg::t_rsp                 o_out_data;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rnb_pkg::APB_AW-1:0]    paddr = '0;
    logic [rnb_pkg::APB_DW-1:0]    pwdata = '0;
    logic [rnb_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    int pending;
    int mismatches;
    bit in_no_gaps = 1'b0;
    bit out_no_stall = 1'b0;
    int stored_guess = 0;
    int items_sent = 0;

    always #2 i_clk = ~i_clk;

    radius_neighbor_graph_builder_unit #(
        .MAX_POINTS (NUM_POINTS),
        .MAX_DEGREE (NUM_DEGREE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    neighbor_graph_checker #(
        .MAX_POINTS (NUM_POINTS),
        .MAX_DEGREE (NUM_DEGREE)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    function automatic rnb_pkg::t_req make_req(logic [1:0] kind, logic [CW-1:0] x,
                                               logic [CW-1:0] y, logic [CW-1:0] z,
                                               logic [IW-1:0] a, logic [IW-1:0] b);
        rnb_pkg::t_req r;
        r.req_type = kind;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        r.first_point = a;
        r.second_point = b;
        return r;
    endfunction

    function automatic rnb_pkg::t_req random_req();
        return make_req(2'($urandom_range(0, 3)), CW'($urandom), CW'($urandom),
                        CW'($urandom), IW'($urandom), IW'($urandom));
    endfunction

    function automatic logic [CW-1:0] pick_coord(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return CW'(v);
    endfunction

    function automatic logic [IW-1:0] pick_index();
        if (stored_guess > 0 && $urandom_range(0, 6) != 0)
            return IW'($urandom_range(0, stored_guess - 1));
        return IW'($urandom);
    endfunction

    task automatic send_item(rnb_pkg::t_req r);
        int gap;
        gap = in_no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        case (r.req_type)
            rnb_pkg::REQ_CLEAR: stored_guess = 0;
            rnb_pkg::REQ_ADD: if (stored_guess < NUM_POINTS) stored_guess++;
            default: begin
            end
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_link_distance(logic [rnb_pkg::APB_DW-1:0] word);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rnb_pkg::APB_AW'(4 * int'(rnb_pkg::REG_LINK_DISTANCE));
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(int phase_no);
        logic [DW-1:0]                link_pick;
        logic [rnb_pkg::APB_DW-1:0]   word;
        int                           steps;
        int                           spread;
        int                           cx;
        int                           cy;
        int                           cz;
        int                           pick;
        bit                           fill_up;
        case (phase_no == 0 ? 0 : $urandom_range(0, 4))
            0: link_pick = '0;
            1: link_pick = LINK_DIST_MAX;
            2: link_pick = DW'($urandom_range(0, 3));
            3: link_pick = DW'($urandom_range(0, 4000));
            default: link_pick = DW'($urandom_range(0, int'(LINK_DIST_MAX)));
        endcase
        word = $urandom;
        word[DW-1:0] = link_pick;
        if ($urandom_range(0, 3) != 0)
            word[rnb_pkg::APB_DW-1:DW] = '0;
        set_link_distance(word);
        in_no_gaps = ($urandom_range(0, 3) == 0);
        out_no_stall = ($urandom_range(0, 3) == 0);

        send_item(make_req(rnb_pkg::REQ_CLEAR, CW'($urandom), CW'($urandom),
                           CW'($urandom), IW'($urandom), IW'($urandom)));
        if ($urandom_range(0, 9) == 0) begin
            repeat (40) send_item(random_req());
        end else begin
            fill_up = ($urandom_range(0, 3) == 0);
            steps = fill_up ? 130 : $urandom_range(8, 70);
            if (link_pick == '0)
                spread = $urandom_range(0, 1);
            else
                spread = int'(link_pick) * $urandom_range(1, 12) / 8 + 1;
            if (spread > 70000)
                spread = 70000;
            cx = $urandom_range(0, 65535) - 32768;
            cy = $urandom_range(0, 65535) - 32768;
            cz = $urandom_range(0, 65535) - 32768;
            for (int s = 0; s < steps; s++) begin
                pick = $urandom_range(0, 99);
                if (pick < (fill_up ? 70 : 55))
                    send_item(make_req(rnb_pkg::REQ_ADD, pick_coord(cx, spread),
                                       pick_coord(cy, spread), pick_coord(cz, spread),
                                       IW'($urandom), IW'($urandom)));
                else if (pick < 93)
                    send_item(make_req(rnb_pkg::REQ_QUERY, CW'($urandom), CW'($urandom),
                                       CW'($urandom), pick_index(), pick_index()));
                else if (pick < 97 || fill_up)
                    send_item(random_req());
                else
                    send_item(make_req(rnb_pkg::REQ_CLEAR, '0, '0, '0, '0, '0));
            end
        end
    endtask

    initial begin
        int stall;
        forever begin
            stall = out_no_stall ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin
        int phase_no;
        phase_no = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_link_distance(rnb_pkg::APB_DW'(100));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, '0, '0));
        send_item(make_req(REQ_UNUSED, '1, '1, '1, '1, '1));
        send_item(make_req(rnb_pkg::REQ_ADD, '0, '0, '0, '0, '0));
        send_item(make_req(rnb_pkg::REQ_ADD, 16'd100, '0, '0, '1, '1));
        send_item(make_req(rnb_pkg::REQ_ADD, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0));
        send_item(make_req(rnb_pkg::REQ_ADD, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0));
        send_item(make_req(rnb_pkg::REQ_ADD, 16'd60, 16'd80, '0, '0, '0));
        send_item(make_req(rnb_pkg::REQ_ADD, '0, '0, 16'd101, '0, '0));
        send_item(make_req(rnb_pkg::REQ_QUERY, '1, '1, '1, 6'd0, 6'd1));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd1, 6'd0));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd0, 6'd0));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd2, 6'd3));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd63, 6'd0));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd4, 6'd1));
        send_item(make_req(rnb_pkg::REQ_CLEAR, '1, '1, '1, '1, '1));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd0, 6'd1));

        set_link_distance('1);
        send_item(make_req(rnb_pkg::REQ_ADD, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0));
        send_item(make_req(rnb_pkg::REQ_ADD, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0));
        send_item(make_req(rnb_pkg::REQ_QUERY, '0, '0, '0, 6'd1, 6'd0));
        repeat (9)
            send_item(make_req(rnb_pkg::REQ_ADD, CW'($urandom), CW'($urandom),
                               CW'($urandom), '0, '0));

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            run_phase(phase_no);
            phase_no++;
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (mismatches == 0)
            $display("radius_neighbor_graph_builder_unit: match");
        else
            $display("radius_neighbor_graph_builder_unit: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("radius_neighbor_graph_builder_unit: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rnb_pkg.sv
rtl/rnb_ram.sv
rtl/radius_neighbor_graph_builder_unit.sv
bench/neighbor_graph_checker.sv
bench/tb_radius_neighbor_graph_builder_unit.sv
